### src/adl_pkg.sv
// ----------------------------------------------------------------------------
// adl_pkg
// Shared types and constants of the Adler-32 stream checksum.
// ----------------------------------------------------------------------------
package adl_pkg;

  // Adler-32 modulus and the initial sums
  localparam logic [15:0] ADLER_MOD  = 16'd65521;
  localparam logic [15:0] LOW_INIT   = 16'd1;
  localparam logic [15:0] HIGH_INIT  = 16'd0;

  // Bytes that one data word carries
  localparam int WORD_BYTES = 4;

  // Field widths
  localparam int CNT_W  = 3;   // byte count
  localparam int BSUM_W = 10;  // sum of up to four bytes
  localparam int WSUM_W = 13;  // weighted byte sum, weights up to 7

  // One classified word, handed from the front end to the back end
  typedef struct packed {
    logic [CNT_W-1:0]  n_bytes;   // saturated byte count
    logic [BSUM_W-1:0] byte_sum;  // sum of the taken bytes
    logic [WSUM_W-1:0] wsum;      // sum of (n - i) * byte i
    logic              start;     // restart sums first
    logic              last;      // emit checksum afterwards
  } adl_item_t;

endpackage

### src/adler32_stream_checksum.sv
// ----------------------------------------------------------------------------
// adler32_stream_checksum
// Running Adler-32 checksum over a stream of words of up to four bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per accepted cycle, bytes
//   taken from bits 7:0 upward, in_byte_count of them (limited to
//   BYTES_PER_ITEM; positions past the word count as zero bytes).
//   in_start_flag restarts the sums (low 1, high 0) before the word's bytes;
//   in_end_flag makes the word produce one checksum, high sum above low sum.
//   Output channel (out_valid / out_stall): one word per end-flagged input.
//   Throughput: one input word per cycle, unless a held checksum fills
//   the queue. The front end folds a word into a byte sum and a weighted
//   sum; the back end applies it, so the sum register loop sets the rate.
//   Path: an accepted word is written into the queue, the back end applies
//   it to the sums, and an end word's checksum goes to the output register.
//   Stall: a two-entry queue separates the two ends; while out_stall holds a
//   checksum, words without an end flag keep flowing, and in_stall rises
//   only once the queue is full.
//   Reset: synchronous, active low; sums return to their initial values and
//   both the queue and the output register empty.
// ----------------------------------------------------------------------------
module adler32_stream_checksum
  import adl_pkg::*;
#(
  parameter int BYTES_PER_ITEM = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_data_word,
  input  logic [CNT_W-1:0] in_byte_count,
  input  logic             in_start_flag,
  input  logic             in_end_flag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_checksum
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;
  adl_item_t push_item;
  adl_item_t head_item;

  // Front end: accept and classify
  adl_front #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_start_flag (in_start_flag),
    .in_end_flag   (in_end_flag),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // Decoupling queue
  adl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back end: sums and output register
  adl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule

### src/adl_front.sv
// ----------------------------------------------------------------------------
// adl_front
// Accepts input words, saturates the count and folds the bytes into a
// plain sum and a position-weighted sum that do not depend on the state.
// ----------------------------------------------------------------------------
module adl_front
  import adl_pkg::*;
#(
  parameter int BYTES_PER_ITEM = 4
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_data_word,
  input  logic [CNT_W-1:0] in_byte_count,
  input  logic             in_start_flag,
  input  logic             in_end_flag,
  input  logic             q_full,
  output logic             q_push,
  output adl_item_t        q_item
);

  // The count field cannot exceed its own range, so clip the limit to it
  localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
  localparam int CNT_LIMIT     = (BYTES_PER_ITEM > CNT_FIELD_MAX) ?
                                 CNT_FIELD_MAX : BYTES_PER_ITEM;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(CNT_LIMIT);

  // Handshake: take a word whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify: bytes past the word read as zero, so only the four real
  // positions contribute to the sums; the count still weights high_sum.
  always_comb begin
    logic [CNT_W-1:0]  n;
    logic [BSUM_W-1:0] bsum;
    logic [WSUM_W-1:0] wsum;
    logic [7:0]        b;
    logic [CNT_W-1:0]  w;
    n    = (in_byte_count > CNT_SAT) ? CNT_SAT : in_byte_count;
    bsum = '0;
    wsum = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      b = in_data_word[8*i +: 8];
      w = n - CNT_W'(i);
      if (CNT_W'(i) < n) begin
        bsum = bsum + {{(BSUM_W-8){1'b0}}, b};
        wsum = wsum + ({{(WSUM_W-CNT_W){1'b0}}, w} * {{(WSUM_W-8){1'b0}}, b});
      end
    end
    q_item.n_bytes  = n;
    q_item.byte_sum = bsum;
    q_item.wsum     = wsum;
    q_item.start    = in_start_flag;
    q_item.last     = in_end_flag;
  end

endmodule

### src/adl_queue.sv
// ----------------------------------------------------------------------------
// adl_queue
// Two-entry queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module adl_queue
  import adl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  adl_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output adl_item_t head_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  adl_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue fill count out of range");

endmodule

### src/adl_back.sv
// ----------------------------------------------------------------------------
// adl_back
// Applies one classified word per cycle to the sums, end words only when the
// output register is free; it holds the checksum until the receiver takes it.
// ----------------------------------------------------------------------------
module adl_back
  import adl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  adl_item_t   q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_checksum
);

  logic [15:0] low_r, low_nxt;
  logic [15:0] high_r, high_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_checksum_r;
  logic        out_free;
  logic        load_out;

  // Sum update: low += S, high += n*low + W, both reduced mod 65521
  always_comb begin
    logic [15:0] base_l;
    logic [15:0] base_h;
    logic [16:0] l_sum;
    logic [18:0] nl;
    logic [19:0] h_t;
    logic [3:0]  h_hi;
    logic [16:0] h_u;
    base_l = q_item.start ? LOW_INIT  : low_r;
    base_h = q_item.start ? HIGH_INIT : high_r;

    // low: both terms below the modulus, one subtract at most
    l_sum   = {1'b0, base_l} + {{(17-BSUM_W){1'b0}}, q_item.byte_sum};
    low_nxt = (l_sum >= {1'b0, ADLER_MOD}) ? 16'(l_sum - {1'b0, ADLER_MOD})
                                           : l_sum[15:0];

    // n * low by shift and add, n has three bits
    nl = ({3'b000, base_l}       & {19{q_item.n_bytes[0]}}) +
         ({2'b00, base_l, 1'b0}  & {19{q_item.n_bytes[1]}}) +
         ({1'b0, base_l, 2'b00}  & {19{q_item.n_bytes[2]}});
    h_t = {4'b0000, base_h} + {1'b0, nl} + {{(20-WSUM_W){1'b0}}, q_item.wsum};

    // fold bits above 16 back in: 2^16 = 15 mod 65521
    h_hi = h_t[19:16];
    h_u  = ({9'b0, h_hi, 4'b0000} - {13'b0, h_hi}) + {1'b0, h_t[15:0]};
    high_nxt = (h_u >= {1'b0, ADLER_MOD}) ? 16'(h_u - {1'b0, ADLER_MOD})
                                          : h_u[15:0];
  end

  // Output register frees up when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && (!q_item.last || out_free);
  assign load_out = q_pop && q_item.last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= LOW_INIT;
      high_r      <= HIGH_INIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_checksum_r <= {high_nxt, low_nxt};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

  // Checks
  a_low_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    low_r < ADLER_MOD) else $error("low sum not reduced");
  a_high_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    high_r < ADLER_MOD) else $error("high sum not reduced");
  a_end_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r) else $error("end word did not raise out_valid");
  a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_pop) |-> (q_item.last && out_valid_r && out_stall))
    else $error("back end held a word without cause");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Adler-32 stream checksum. A short table of directed
// words comes first, with the checksum typed in where it is obvious. Random
// messages with random contents follow, mixed with stray words. The sender
// works in bursts and the receiver stalls on its own pattern, with one long
// hold-off that fills the block. Every checksum is compared in order with its
// typed-in value or else with a running model of the sums.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import adl_pkg::*;

  localparam int BYTES_PER_ITEM = 4;
  localparam int RAND_WORDS     = 1100;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_WORD   = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_SHOWN      = 50;

  // one input word plus an optional typed-in checksum
  typedef struct packed {
    logic [31:0]      data;
    logic [CNT_W-1:0] cnt;
    logic             start;
    logic             last;
    logic             has_fixed;
    logic [31:0]      fixed_sum;
  } word_row_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_checksum;
  word_row_t   drv;

  // running sums of the model
  logic [15:0] run_low;
  logic [15:0] run_high;

  logic [31:0] checksum_queue[$];
  int          words_in   = 0;
  int          err_count  = 0;
  int          cycle_cnt  = 0;
  int          burst_left = 0;
  bit          hold_done  = 1'b0;

  word_row_t   dir_table [16];

  adler32_stream_checksum #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_word (drv.data),
    .in_byte_count(drv.cnt),
    .in_start_flag(drv.start),
    .in_end_flag  (drv.last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // fold one word's bytes into the running sums
  function automatic void fold_word(input word_row_t w);
    int n;
    int b;
    int lo;
    int hi;
    n = (w.cnt > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(w.cnt);
    if (w.start) begin
      lo = int'(LOW_INIT);
      hi = int'(HIGH_INIT);
    end else begin
      lo = int'(run_low);
      hi = int'(run_high);
    end
    for (int i = 0; i < n; i++) begin
      // positions past the word read as zero bytes
      b = (i < WORD_BYTES) ? int'(w.data[8*i +: 8]) : 0;
      lo = (lo + b) % int'(ADLER_MOD);
      hi = (hi + lo) % int'(ADLER_MOD);
    end
    run_low  = lo[15:0];
    run_high = hi[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_SHOWN)
      $display("%0t ns: %s: expected %08h, got %08h", $time, what, want, got);
  endtask

  // offer one word; the sender works in bursts with idle gaps between them
  task automatic send_word(input word_row_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    drv      = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // accepted input words drive the model
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      fold_word(drv);
      words_in++;
      if (drv.last)
        checksum_queue.push_back(drv.has_fixed ? drv.fixed_sum : {run_high, run_low});
    end
  end

  // accepted checksums against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (checksum_queue.size() == 0)
        report_mismatch("unexpected checksum", 32'h0, out_checksum);
      else if (out_checksum !== checksum_queue[0])
        report_mismatch("checksum", checksum_queue.pop_front(), out_checksum);
      else
        void'(checksum_queue.pop_front());
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is going
  initial begin : rx_stall_gen
    rx_mode_t mode;
    int       span;
    out_stall = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (!hold_done && words_in >= HOLD_AT_WORD) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          RX_FREE:     out_stall = 1'b0;
          RX_LIGHT:    out_stall = ($urandom_range(0, 9) < 3);
          RX_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
          RX_PERIODIC: out_stall = ((c % 5) < 3);
          default:     out_stall = 1'b0;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin : stim
    word_row_t row;
    int        msg_len;
    int        fill_ff;
    int        msg_no;
    int        sent;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    drv      = '0;
    run_low  = LOW_INIT;
    run_high = HIGH_INIT;
    msg_no   = 0;
    sent     = 0;

    // data, count, start, end, typed, checksum
    dir_table = '{
      // right after reset: initial value
      '{32'h00000000, 3'd0, 1'b0, 1'b1, 1'b1, 32'h00000001},
      // four 0xff bytes
      '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, 1'b1, 32'h09FA03FD},
      // count above the limit saturates to four
      '{32'hFFFFFFFF, 3'd7, 1'b1, 1'b1, 1'b1, 32'h09FA03FD},
      '{32'h00000000, 3'd5, 1'b1, 1'b1, 1'b1, 32'h00040001},
      '{32'h000000FF, 3'd1, 1'b1, 1'b1, 1'b1, 32'h01000100},
      // zero count with start and end together
      '{32'h12345678, 3'd0, 1'b1, 1'b1, 1'b1, 32'h00000001},
      '{32'hDEADBEEF, 3'd4, 1'b1, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 3'd0, 1'b0, 1'b0, 1'b0, 32'h0},
      '{32'hA5A5A5A5, 3'd2, 1'b0, 1'b0, 1'b0, 32'h0},
      '{32'h5A5A5A5A, 3'd3, 1'b0, 1'b1, 1'b0, 32'h0},
      // carries on after an end without a new start
      '{32'h01020304, 3'd6, 1'b0, 1'b1, 1'b0, 32'h0},
      '{32'h80000001, 3'd4, 1'b1, 1'b0, 1'b0, 32'h0},
      // restart in the middle of a message
      '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b0, 1'b0, 32'h0},
      '{32'h7FFFFFFF, 3'd3, 1'b0, 1'b1, 1'b0, 32'h0},
      '{32'hFFFFFFFF, 3'd4, 1'b0, 1'b0, 1'b0, 32'h0},
      '{32'h00000000, 3'd0, 1'b0, 1'b1, 1'b0, 32'h0}
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i]) send_word(dir_table[i]);

    // random messages, with some stray words and missing starts
    while (sent < RAND_WORDS) begin
      row = '0;
      if ($urandom_range(0, 9) == 0) begin
        row.data  = $urandom;
        row.cnt   = CNT_W'($urandom_range(0, 7));
        row.start = 1'($urandom_range(0, 1));
        row.last  = 1'($urandom_range(0, 1));
        send_word(row);
        sent++;
      end else begin
        // the first message is long and all ones to wrap both sums
        if (msg_no == 0) begin
          msg_len = 100;
          fill_ff = 1;
        end else begin
          msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                                : $urandom_range(1, 8);
          fill_ff = int'($urandom_range(0, 3) == 0);
        end
        msg_no++;
        for (int k = 0; k < msg_len; k++) begin
          row.data  = (fill_ff != 0) ? 32'hFFFFFFFF : $urandom;
          row.cnt   = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                                  : CNT_W'(4);
          row.start = (k == 0) && ($urandom_range(0, 7) != 0);
          row.last  = (k == msg_len - 1);
          send_word(row);
          sent++;
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (checksum_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
